FILE: hw/rtl/crystal_ball_shape_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Crystal ball shape evaluator assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CRYSTAL_BALL_SHAPE_EVALUATOR_ASSERT_SVH
`define CRYSTAL_BALL_SHAPE_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define CBSE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBSE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cbse_pkg.sv
// ----------------------------------------------------------------------------
// Crystal ball shape evaluator package
// Widths, codes, sideband structs and constant helpers for the pipeline.
// ----------------------------------------------------------------------------
package cbse_pkg;

    localparam int MASS_W     = 24;
    localparam int SHAPE_W    = 32;
    localparam int ALPHA_W    = 16;
    localparam int POWER_W    = 16;
    localparam int WIDTH_W    = 24;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int ZMAG_W  = 23;
    localparam int AMAG_W  = 20;
    localparam int NPOW_W  = 22;
    localparam int AD_W    = 43;
    localparam int T_W     = 36;
    localparam int V_W     = 37;
    localparam int POS_W   = 6;
    localparam int INT_W   = 5;
    localparam int FRAC_W  = 16;
    localparam int LG_W    = INT_W + FRAC_W;
    localparam int E_W     = 30;
    localparam int K_W     = E_W - FRAC_W;
    localparam int M_W     = 31;
    localparam int COEF_W  = 30;
    localparam int SQS_W   = 29;

    localparam logic [ZMAG_W-1:0] ZCAP      = 23'h400000;
    localparam logic [30:0]       LOG2E_Q30 = 31'd1549082005;
    localparam logic [POS_W-1:0]  LOG_BIAS  = 6'd16;
    localparam logic [5:0]        EXP_Q     = 6'd30;
    localparam logic [K_W-1:0]    K_MAX     = 14'd33;

    typedef logic [1:0] region_t;
    localparam region_t REGION_CORE    = 2'd0;
    localparam region_t REGION_LEFT    = 2'd1;
    localparam region_t REGION_RIGHT   = 2'd2;
    localparam region_t REGION_INVALID = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ALPHA_LEFT  = 3'd0;
    localparam cfg_idx_t CFG_ALPHA_RIGHT = 3'd1;
    localparam cfg_idx_t CFG_POWER_LEFT  = 3'd2;
    localparam cfg_idx_t CFG_POWER_RIGHT = 3'd3;
    localparam cfg_idx_t CFG_WIDTH       = 3'd4;
    localparam cfg_idx_t CFG_CENTRE      = 3'd5;
    localparam cfg_idx_t CFG_PEAK_SCALE  = 3'd6;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd4096;
    localparam logic [POWER_W-1:0] POWER_RST = 16'd2048;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 24'd83886;
    localparam logic [WIDTH_W-1:0] CENTRE_RST = 24'd8388608;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd256;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic wzero;
    } front_side_t;

    typedef struct packed {
        region_t           region;
        logic [E_W-1:0]    hexp;
        logic [NPOW_W-1:0] npow;
        logic              use_lg;
    } tail_side_t;

    function automatic logic [AMAG_W-1:0] alpha_mag(input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] m;
        m = a[ALPHA_W-1] ? ALPHA_W'(-a) : a;
        return {m, 4'b0};
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = '0;
        b = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-(idx+1)) in Q.30
    function automatic logic [63:0] pow2_coef(input int idx);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 0; j < FRAC_W; j++) begin
            if (j < idx) begin
                c = isqrt64(c << 30);
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/cbse_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the dividend's top part must be below the divisor.
// ----------------------------------------------------------------------------
module cbse_div #(
    parameter int DEN_W  = 24,
    parameter int QUO_W  = 23,
    parameter int SIDE_W = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DEN_W+QUO_W-1:0] in_num,
    input  logic [DEN_W-1:0]       in_den,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic [QUO_W-1:0]  valid_reg;
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0]  lq_reg   [QUO_W];
    logic [QUO_W-1:0]  lq_next  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [DEN_W-1:0]  rem_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [QUO_W-1:0]  lq_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [DEN_W:0]    trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign rem_prev   = in_num[DEN_W+QUO_W-1:QUO_W];
            assign lq_prev    = in_num[QUO_W-1:0];
            assign den_prev   = in_den;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign rem_prev   = rem_reg[i-1];
            assign lq_prev    = lq_reg[i-1];
            assign den_prev   = den_reg[i-1];
            assign side_prev  = side_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        assign trial       = {rem_prev, lq_prev[QUO_W-1]};
        assign ge          = trial >= {1'b0, den_prev};
        assign rem_next[i] = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
        assign lq_next[i]  = {lq_prev[QUO_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next[i];
                lq_reg[i]   <= lq_next[i];
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = lq_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

FILE: hw/rtl/cbse_log2.sv
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// log2(1 + t) in Q.16: leading-one search, normalise, then one squaring a bit.
// ----------------------------------------------------------------------------
module cbse_log2 #(
    parameter int SIDE_W = 55
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cbse_pkg::T_W-1:0]      in_t,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [cbse_pkg::LG_W-1:0]     out_lg,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int NSQ = cbse_pkg::FRAC_W;

    logic                           va_valid_reg;
    logic [cbse_pkg::V_W-1:0]       va_v_reg;
    logic [SIDE_W-1:0]              va_side_reg;
    logic                           pb_valid_reg;
    logic [cbse_pkg::V_W-1:0]       pb_v_reg;
    logic [cbse_pkg::POS_W-1:0]     pb_pos_reg;
    logic [cbse_pkg::POS_W-1:0]     pb_pos_next;
    logic [SIDE_W-1:0]              pb_side_reg;
    logic                           nm_valid_reg;
    logic [cbse_pkg::M_W-1:0]       nm_m_reg;
    logic [cbse_pkg::INT_W-1:0]     nm_int_reg;
    logic [SIDE_W-1:0]              nm_side_reg;
    logic [cbse_pkg::V_W+29:0]      norm_wide;

    logic [NSQ-1:0]                 sq_valid_reg;
    logic [cbse_pkg::M_W-1:0]       sq_m_reg    [NSQ];
    logic [cbse_pkg::FRAC_W-1:0]    sq_frac_reg [NSQ];
    logic [cbse_pkg::INT_W-1:0]     sq_int_reg  [NSQ];
    logic [SIDE_W-1:0]              sq_side_reg [NSQ];

    always_comb begin
        pb_pos_next = '0;
        for (int i = 0; i < cbse_pkg::V_W; i++) begin
            if (va_v_reg[i]) begin
                pb_pos_next = cbse_pkg::POS_W'(i);
            end
        end
    end

    assign norm_wide = ({30'b0, pb_v_reg} << 30) >> pb_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
            nm_valid_reg <= 1'b0;
        end else if (en) begin
            va_valid_reg <= in_valid;
            pb_valid_reg <= va_valid_reg;
            nm_valid_reg <= pb_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            va_v_reg    <= {1'b0, in_t} + cbse_pkg::V_W'(17'h10000);
            va_side_reg <= in_side;
            pb_v_reg    <= va_v_reg;
            pb_pos_reg  <= pb_pos_next;
            pb_side_reg <= va_side_reg;
            nm_m_reg    <= norm_wide[cbse_pkg::M_W-1:0];
            nm_int_reg  <= cbse_pkg::INT_W'(pb_pos_reg - cbse_pkg::LOG_BIAS);
            nm_side_reg <= pb_side_reg;
        end
    end

    for (genvar i = 0; i < NSQ; i++) begin : g_sq
        logic [cbse_pkg::M_W-1:0]     m_prev;
        logic [cbse_pkg::FRAC_W-1:0]  frac_prev;
        logic [cbse_pkg::INT_W-1:0]   int_prev;
        logic [SIDE_W-1:0]            side_prev;
        logic                         valid_prev;
        logic [2*cbse_pkg::M_W-1:0]   sq;
        logic [cbse_pkg::M_W:0]       mm;

        if (i == 0) begin : g_first
            assign m_prev     = nm_m_reg;
            assign frac_prev  = '0;
            assign int_prev   = nm_int_reg;
            assign side_prev  = nm_side_reg;
            assign valid_prev = nm_valid_reg;
        end else begin : g_rest
            assign m_prev     = sq_m_reg[i-1];
            assign frac_prev  = sq_frac_reg[i-1];
            assign int_prev   = sq_int_reg[i-1];
            assign side_prev  = sq_side_reg[i-1];
            assign valid_prev = sq_valid_reg[i-1];
        end

        assign sq = {31'b0, m_prev} * {31'b0, m_prev};
        assign mm = sq[2*cbse_pkg::M_W-1:30];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[i] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_m_reg[i]    <= mm[cbse_pkg::M_W] ? mm[cbse_pkg::M_W:1]
                                                    : mm[cbse_pkg::M_W-1:0];
                sq_frac_reg[i] <= {frac_prev[cbse_pkg::FRAC_W-2:0], mm[cbse_pkg::M_W]};
                sq_int_reg[i]  <= int_prev;
                sq_side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = sq_valid_reg[NSQ-1];
    assign out_lg    = {sq_int_reg[NSQ-1], sq_frac_reg[NSQ-1]};
    assign out_side  = sq_side_reg[NSQ-1];

endmodule

FILE: hw/rtl/cbse_exp2.sv
// ----------------------------------------------------------------------------
// Pipelined scaled power of two
// peak * 2^-E: one constant factor per fraction bit, then scale, round, saturate or zero.
// ----------------------------------------------------------------------------
module cbse_exp2 #(
    parameter int SIDE_W = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cbse_pkg::E_W-1:0]      in_e,
    input  logic [SIDE_W-1:0]             in_side,
    input  logic [cbse_pkg::SCALE_W-1:0]  peak_scale,
    output logic                          out_valid,
    output logic [cbse_pkg::SHAPE_W-1:0]  out_shape,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int NST = cbse_pkg::FRAC_W;

    logic [NST-1:0]               pw_valid_reg;
    logic [cbse_pkg::M_W-1:0]     pw_p_reg    [NST];
    logic [cbse_pkg::K_W-1:0]     pw_k_reg    [NST];
    logic [cbse_pkg::FRAC_W-1:0]  pw_f_reg    [NST];
    logic [SIDE_W-1:0]            pw_side_reg [NST];

    logic                         mu_valid_reg;
    logic [62:0]                  mu_prod_reg;
    logic [cbse_pkg::K_W-1:0]     mu_k_reg;
    logic [SIDE_W-1:0]            mu_side_reg;

    logic                         zero;
    logic [5:0]                   sh;
    logic [63:0]                  rnd;
    logic [63:0]                  sum;
    logic [63:0]                  shifted;

    for (genvar i = 0; i < NST; i++) begin : g_pw
        localparam logic [cbse_pkg::COEF_W-1:0] C =
            cbse_pkg::COEF_W'(cbse_pkg::pow2_coef(i));
        logic [cbse_pkg::M_W-1:0]              p_prev;
        logic [cbse_pkg::K_W-1:0]              k_prev;
        logic [cbse_pkg::FRAC_W-1:0]           f_prev;
        logic [SIDE_W-1:0]                     side_prev;
        logic                                  valid_prev;
        logic [cbse_pkg::M_W+cbse_pkg::COEF_W-1:0] prod;

        if (i == 0) begin : g_first
            assign p_prev     = cbse_pkg::M_W'(31'h40000000);
            assign k_prev     = in_e[cbse_pkg::E_W-1:cbse_pkg::FRAC_W];
            assign f_prev     = in_e[cbse_pkg::FRAC_W-1:0];
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign p_prev     = pw_p_reg[i-1];
            assign k_prev     = pw_k_reg[i-1];
            assign f_prev     = pw_f_reg[i-1];
            assign side_prev  = pw_side_reg[i-1];
            assign valid_prev = pw_valid_reg[i-1];
        end

        assign prod = (cbse_pkg::M_W+cbse_pkg::COEF_W)'(p_prev)
                    * (cbse_pkg::M_W+cbse_pkg::COEF_W)'(C);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_valid_reg[i] <= 1'b0;
            end else if (en) begin
                pw_valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_p_reg[i]    <= f_prev[cbse_pkg::FRAC_W-1-i]
                                ? prod[cbse_pkg::M_W+29:30] : p_prev;
                pw_k_reg[i]    <= k_prev;
                pw_f_reg[i]    <= f_prev;
                pw_side_reg[i] <= side_prev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_valid_reg <= 1'b0;
        end else if (en) begin
            mu_valid_reg <= pw_valid_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_prod_reg <= 63'(peak_scale) * 63'(pw_p_reg[NST-1]);
            mu_k_reg    <= pw_k_reg[NST-1];
            mu_side_reg <= pw_side_reg[NST-1];
        end
    end

    assign zero    = mu_k_reg > cbse_pkg::K_MAX;
    assign sh      = 6'(mu_k_reg[5:0] + cbse_pkg::EXP_Q);
    assign rnd     = 64'd1 << (sh - 6'd1);
    assign sum     = {1'b0, mu_prod_reg} + rnd;
    assign shifted = sum >> sh;

    assign out_valid = mu_valid_reg;
    assign out_side  = mu_side_reg;
    assign out_shape = zero ? '0 : ((|shifted[63:32]) ? '1 : shifted[31:0]);

endmodule

FILE: hw/rtl/crystal_ball_shape_evaluator.sv
// ----------------------------------------------------------------------------
// Crystal ball shape evaluator
// Double-sided crystal ball value and region code for each mass sample.
// ----------------------------------------------------------------------------
// One sample enters per clock while the pipeline is not held. Most of the
// pipeline's length lies in the two bit-per-stage dividers (23 and 36
// stages), the 16 squaring stages of the logarithm and the 16 factor
// stages of the power of two. When m_tready is low with a result waiting,
// the whole pipeline holds and s_tready drops. Registers are read live by
// the stages that use them: write them only when no sample is in flight.
`include "crystal_ball_shape_evaluator_assert.svh"

module crystal_ball_shape_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] mass_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] shape_value
    output logic [1:0]  m_tuser,    // [1:0] region
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int FS_W = $bits(cbse_pkg::front_side_t);
    localparam int TS_W = $bits(cbse_pkg::tail_side_t);

    logic                            en;

    logic [cbse_pkg::ALPHA_W-1:0]    alpha_left_reg;
    logic [cbse_pkg::ALPHA_W-1:0]    alpha_right_reg;
    logic [cbse_pkg::POWER_W-1:0]    power_left_reg;
    logic [cbse_pkg::POWER_W-1:0]    power_right_reg;
    logic [cbse_pkg::WIDTH_W-1:0]    width_reg;
    logic [cbse_pkg::WIDTH_W-1:0]    centre_reg;
    logic [cbse_pkg::SCALE_W-1:0]    peak_scale_reg;

    logic [cbse_pkg::MASS_W-1:0]     x;
    logic                            fe_valid_reg;
    logic                            fe_neg_reg;
    logic [cbse_pkg::MASS_W-1:0]     fe_mag_reg;
    logic                            fe_ovf_reg;
    logic                            fe_wzero_reg;
    cbse_pkg::front_side_t           fe_side;
    logic [46:0]                     d1_num;
    logic [cbse_pkg::WIDTH_W-1:0]    d1_den;

    logic                            d1_valid;
    logic [cbse_pkg::ZMAG_W-1:0]     d1_quo;
    logic [FS_W-1:0]                 d1_side_vec;
    cbse_pkg::front_side_t           d1_side;

    logic                            zs_valid_reg;
    logic [cbse_pkg::ZMAG_W-1:0]     zs_zmag_reg;
    logic                            zs_neg_reg;
    logic                            zs_wzero_reg;

    logic [cbse_pkg::AMAG_W-1:0]     a_left;
    logic [cbse_pkg::AMAG_W-1:0]     a_right;
    logic                            is_left;
    logic                            is_right;
    logic                            is_tail;
    logic [cbse_pkg::AMAG_W-1:0]     a_sel;
    logic [cbse_pkg::NPOW_W-1:0]     n_sel;
    cbse_pkg::region_t               region_sel;

    logic                            cl_valid_reg;
    cbse_pkg::region_t               cl_region_reg;
    logic [cbse_pkg::AMAG_W-1:0]     cl_a_reg;
    logic [cbse_pkg::ZMAG_W-1:0]     cl_d_reg;
    logic [cbse_pkg::NPOW_W-1:0]     cl_n_reg;
    logic                            cl_use_lg_reg;
    logic [cbse_pkg::ZMAG_W-1:0]     cl_q_reg;

    logic [45:0]                     q_sq;
    logic                            pm_valid_reg;
    cbse_pkg::region_t               pm_region_reg;
    logic [cbse_pkg::AD_W-1:0]       pm_ad_reg;
    logic [cbse_pkg::SQS_W-1:0]      pm_s_reg;
    logic [cbse_pkg::NPOW_W-1:0]     pm_n_reg;
    logic                            pm_use_lg_reg;

    logic [59:0]                     hx_prod;
    logic                            ph_valid_reg;
    cbse_pkg::region_t               ph_region_reg;
    logic [cbse_pkg::AD_W-1:0]       ph_ad_reg;
    logic [cbse_pkg::E_W-1:0]        ph_hexp_reg;
    logic [cbse_pkg::NPOW_W-1:0]     ph_n_reg;
    logic                            ph_use_lg_reg;

    logic [57:0]                     d2_num;
    logic [cbse_pkg::NPOW_W-1:0]     d2_den;
    cbse_pkg::tail_side_t            d2_side_in;
    logic                            d2_valid;
    logic [cbse_pkg::T_W-1:0]        d2_quo;
    logic [TS_W-1:0]                 d2_side_vec;

    logic                            lg_valid;
    logic [cbse_pkg::LG_W-1:0]       lg_val;
    logic [TS_W-1:0]                 lg_side_vec;
    cbse_pkg::tail_side_t            lg_side;

    logic                            gm_valid_reg;
    cbse_pkg::region_t               gm_region_reg;
    logic [cbse_pkg::E_W-1:0]        gm_hexp_reg;
    logic [cbse_pkg::AD_W-1:0]       gm_nl_reg;
    logic                            gm_use_lg_reg;

    logic                            ee_valid_reg;
    logic [cbse_pkg::E_W-1:0]        ee_e_reg;
    cbse_pkg::region_t               ee_region_reg;

    logic                            ex_valid;
    logic [cbse_pkg::SHAPE_W-1:0]    ex_shape;
    cbse_pkg::region_t               ex_region;

    logic                            m_tvalid_reg;
    logic [cbse_pkg::SHAPE_W-1:0]    m_tdata_reg;
    cbse_pkg::region_t               m_tuser_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_left_reg  <= cbse_pkg::ALPHA_RST;
            alpha_right_reg <= cbse_pkg::ALPHA_RST;
            power_left_reg  <= cbse_pkg::POWER_RST;
            power_right_reg <= cbse_pkg::POWER_RST;
            width_reg       <= cbse_pkg::WIDTH_RST;
            centre_reg      <= cbse_pkg::CENTRE_RST;
            peak_scale_reg  <= cbse_pkg::SCALE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbse_pkg::CFG_ALPHA_LEFT: begin
                    alpha_left_reg <= cfg_data[cbse_pkg::ALPHA_W-1:0];
                end
                cbse_pkg::CFG_ALPHA_RIGHT: begin
                    alpha_right_reg <= cfg_data[cbse_pkg::ALPHA_W-1:0];
                end
                cbse_pkg::CFG_POWER_LEFT: begin
                    power_left_reg <= cfg_data[cbse_pkg::POWER_W-1:0];
                end
                cbse_pkg::CFG_POWER_RIGHT: begin
                    power_right_reg <= cfg_data[cbse_pkg::POWER_W-1:0];
                end
                cbse_pkg::CFG_WIDTH: begin
                    width_reg <= cfg_data[cbse_pkg::WIDTH_W-1:0];
                end
                cbse_pkg::CFG_CENTRE: begin
                    centre_reg <= cfg_data[cbse_pkg::WIDTH_W-1:0];
                end
                cbse_pkg::CFG_PEAK_SCALE: begin
                    peak_scale_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // front: offset magnitude and quotient overflow
    assign x = s_tdata[cbse_pkg::MASS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fe_valid_reg <= 1'b0;
        end else if (en) begin
            fe_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fe_neg_reg   <= x < centre_reg;
            fe_mag_reg   <= (x < centre_reg) ? centre_reg - x : x - centre_reg;
            fe_ovf_reg   <= 31'(x < centre_reg ? centre_reg - x : x - centre_reg)
                            >= {width_reg, 7'b0};
            fe_wzero_reg <= width_reg == '0;
        end
    end

    assign fe_side = '{neg: fe_neg_reg, ovf: fe_ovf_reg, wzero: fe_wzero_reg};
    assign d1_num  = (fe_ovf_reg || fe_wzero_reg) ? '0 : {7'b0, fe_mag_reg, 16'b0};
    assign d1_den  = fe_wzero_reg ? cbse_pkg::WIDTH_W'(1) : width_reg;

    cbse_div #(
        .DEN_W  (cbse_pkg::WIDTH_W),
        .QUO_W  (cbse_pkg::ZMAG_W),
        .SIDE_W (FS_W)
    ) u_zdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fe_valid_reg),
        .in_num    (d1_num),
        .in_den    (d1_den),
        .in_side   (fe_side),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_side_vec)
    );

    assign d1_side = d1_side_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zs_valid_reg <= 1'b0;
        end else if (en) begin
            zs_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zs_zmag_reg  <= (d1_side.ovf || d1_quo > cbse_pkg::ZCAP) ? cbse_pkg::ZCAP
                                                                      : d1_quo;
            zs_neg_reg   <= d1_side.neg ^ alpha_left_reg[cbse_pkg::ALPHA_W-1];
            zs_wzero_reg <= d1_side.wzero;
        end
    end

    // classify region
    assign a_left   = cbse_pkg::alpha_mag(alpha_left_reg);
    assign a_right  = cbse_pkg::alpha_mag(alpha_right_reg);
    assign is_left  = !zs_wzero_reg && zs_neg_reg && (zs_zmag_reg > {3'b0, a_left});
    assign is_right = !zs_wzero_reg && !zs_neg_reg && (zs_zmag_reg > {3'b0, a_right});
    assign is_tail  = is_left || is_right;
    assign a_sel    = is_left ? a_left : a_right;
    assign n_sel    = is_left ? {power_left_reg, 6'b0} : {power_right_reg, 6'b0};

    always_comb begin
        region_sel = cbse_pkg::REGION_CORE;
        if (zs_wzero_reg) begin
            region_sel = cbse_pkg::REGION_INVALID;
        end else if (is_left) begin
            region_sel = cbse_pkg::REGION_LEFT;
        end else if (is_right) begin
            region_sel = cbse_pkg::REGION_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_valid_reg <= 1'b0;
        end else if (en) begin
            cl_valid_reg <= zs_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cl_region_reg <= region_sel;
            cl_a_reg      <= a_sel;
            cl_d_reg      <= is_tail ? zs_zmag_reg - {3'b0, a_sel} : '0;
            cl_n_reg      <= n_sel;
            cl_use_lg_reg <= is_tail && (n_sel != '0);
            cl_q_reg      <= is_tail ? {3'b0, a_sel} : zs_zmag_reg;
        end
    end

    assign q_sq = 46'(cl_q_reg) * 46'(cl_q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_valid_reg <= 1'b0;
        end else if (en) begin
            pm_valid_reg <= cl_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pm_region_reg <= cl_region_reg;
            pm_ad_reg     <= cbse_pkg::AD_W'(cl_a_reg) * cbse_pkg::AD_W'(cl_d_reg);
            pm_s_reg      <= q_sq[45:17];
            pm_n_reg      <= cl_n_reg;
            pm_use_lg_reg <= cl_use_lg_reg;
        end
    end

    assign hx_prod = 60'(pm_s_reg) * 60'(cbse_pkg::LOG2E_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_valid_reg <= 1'b0;
        end else if (en) begin
            ph_valid_reg <= pm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_region_reg <= pm_region_reg;
            ph_ad_reg     <= pm_ad_reg;
            ph_hexp_reg   <= hx_prod[59:30];
            ph_n_reg      <= pm_n_reg;
            ph_use_lg_reg <= pm_use_lg_reg;
        end
    end

    assign d2_num     = ph_use_lg_reg ? {15'b0, ph_ad_reg} : '0;
    assign d2_den     = ph_use_lg_reg ? ph_n_reg : cbse_pkg::NPOW_W'(1);
    assign d2_side_in = '{region: ph_region_reg, hexp: ph_hexp_reg,
                          npow: ph_n_reg, use_lg: ph_use_lg_reg};

    cbse_div #(
        .DEN_W  (cbse_pkg::NPOW_W),
        .QUO_W  (cbse_pkg::T_W),
        .SIDE_W (TS_W)
    ) u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ph_valid_reg),
        .in_num    (d2_num),
        .in_den    (d2_den),
        .in_side   (d2_side_in),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_side_vec)
    );

    cbse_log2 #(
        .SIDE_W (TS_W)
    ) u_log2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_valid),
        .in_t      (d2_quo),
        .in_side   (d2_side_vec),
        .out_valid (lg_valid),
        .out_lg    (lg_val),
        .out_side  (lg_side_vec)
    );

    assign lg_side = lg_side_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gm_valid_reg <= 1'b0;
            ee_valid_reg <= 1'b0;
        end else if (en) begin
            gm_valid_reg <= lg_valid;
            ee_valid_reg <= gm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gm_region_reg <= lg_side.region;
            gm_hexp_reg   <= lg_side.hexp;
            gm_nl_reg     <= cbse_pkg::AD_W'(lg_side.npow) * cbse_pkg::AD_W'(lg_val);
            gm_use_lg_reg <= lg_side.use_lg;
            ee_e_reg      <= gm_hexp_reg
                           + (gm_use_lg_reg ? cbse_pkg::E_W'(gm_nl_reg[cbse_pkg::AD_W-1:16])
                                            : '0);
            ee_region_reg <= gm_region_reg;
        end
    end

    cbse_exp2 #(
        .SIDE_W ($bits(cbse_pkg::region_t))
    ) u_exp2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (ee_valid_reg),
        .in_e       (ee_e_reg),
        .in_side    (ee_region_reg),
        .peak_scale (peak_scale_reg),
        .out_valid  (ex_valid),
        .out_shape  (ex_shape),
        .out_side   (ex_region)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= ex_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= (ex_region == cbse_pkg::REGION_INVALID) ? '0 : ex_shape;
            m_tuser_reg <= ex_region;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CBSE_ASSERT_IMP(a_invalid_zero, aclk, aresetn,
        m_tvalid_reg && (m_tuser_reg == cbse_pkg::REGION_INVALID), m_tdata_reg == '0,
        "invalid setup beat carries a non-zero value")
    `CBSE_ASSERT_IMP(a_zmag_capped, aclk, aresetn,
        zs_valid_reg, zs_zmag_reg <= cbse_pkg::ZCAP,
        "offset magnitude above cap")
    `CBSE_ASSERT_IMP(a_tail_past_switch, aclk, aresetn,
        cl_valid_reg && ((cl_region_reg == cbse_pkg::REGION_LEFT)
                      || (cl_region_reg == cbse_pkg::REGION_RIGHT)), cl_d_reg != '0,
        "tail beat with zero distance past switch point")
    `CBSE_ASSERT_NXT(a_stall_holds, aclk, aresetn,
        !en, $stable(ee_e_reg) && $stable(ee_valid_reg) && $stable(zs_zmag_reg),
        "pipeline moved during stall")

endmodule

FILE: tb/tb_crystal_ball_shape_evaluator.sv
// ----------------------------------------------------------------------------
// Crystal ball shape evaluator testbench
// Streams mass samples through the evaluator under many register settings.
// A short directed table covers the field extremes, both tails, the switch
// boundaries, zero width, zero power, zero alpha and the most negative alpha.
// Random phases follow, each with fresh settings and its own idling mix.
// Every result beat is compared with the entry at the head of the
// expected-result queue: a bit-exact prediction or a fixed known value.
// ----------------------------------------------------------------------------
module tb_crystal_ball_shape_evaluator;

    localparam cbse_pkg::cfg_idx_t CFG_UNUSED = 3'd7;
    localparam int PIPE_WAIT = 120;

    typedef struct packed {
        logic [31:0]       shape;
        cbse_pkg::region_t rgn;
    } shape_out_t;

    typedef struct {
        bit                 wr;
        cbse_pkg::cfg_idx_t idx;
        logic [31:0]        val;
        bit                 known;
        shape_out_t         res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [15:0] alpha_l_q, alpha_r_q, power_l_q, power_r_q;
    logic [23:0] width_q, centre_q;
    logic [31:0] scale_q;
    logic [63:0] half_coef[16];

    shape_out_t  pending[$];
    stim_row_t   directed_rows[$];
    int          mismatches;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_left;
    logic        hold_go;

    crystal_ball_shape_evaluator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] val);
        logic [63:0] v, r, b;
        v = val;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_frac16(logic [63:0] v);
        int          p;
        logic [63:0] m, frac;
        p = 63;
        frac = '0;
        while (p > 0 && !v[p]) p--;
        m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(p - 16) << 16) | frac;
    endfunction

    function automatic logic [63:0] gauss_exponent(logic [63:0] q);
        logic [63:0] s;
        s = (q * q) >> 17;
        return (s * 64'd1549082005) >> 30;
    endfunction

    function automatic logic [63:0] tail_exponent(logic [63:0] a, logic [63:0] n,
                                                  logic [63:0] d);
        logic [63:0] e;
        e = gauss_exponent(a);
        if (n != 0) e = e + ((n * log2_frac16((64'd1 << 16) + (a * d) / n)) >> 16);
        return e;
    endfunction

    function automatic logic [31:0] scaled_power(logic [63:0] e);
        logic [63:0] k, p, prod, sh;
        k = e >> 16;
        p = 64'd1 << 30;
        for (int i = 15; i >= 0; i--) begin
            if (e[i]) p = (p * half_coef[i]) >> 30;
        end
        if (k > 33) return '0;
        sh = 30 + k;
        prod = ({32'd0, scale_q} * p + (64'd1 << (sh - 1))) >> sh;
        return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    function automatic logic [63:0] alpha_q16(logic [15:0] a);
        logic [16:0] m;
        m = a[15] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
        return 64'(m) << 4;
    endfunction

    function automatic shape_out_t predict_shape(logic [23:0] x);
        shape_out_t  r;
        logic        neg;
        logic [63:0] mag, zmag, al, ar, e;
        if (width_q == 0) begin
            r.shape = '0;
            r.rgn = cbse_pkg::REGION_INVALID;
            return r;
        end
        neg = x < centre_q;
        mag = neg ? 64'(centre_q - x) : 64'(x - centre_q);
        zmag = (mag << 16) / width_q;
        if (zmag > (64'd64 << 16)) zmag = 64'd64 << 16;
        if (alpha_l_q[15]) neg = !neg;
        al = alpha_q16(alpha_l_q);
        ar = alpha_q16(alpha_r_q);
        if (neg && zmag > al) begin
            r.rgn = cbse_pkg::REGION_LEFT;
            e = tail_exponent(al, 64'(power_l_q) << 6, zmag - al);
        end else if (!neg && zmag > ar) begin
            r.rgn = cbse_pkg::REGION_RIGHT;
            e = tail_exponent(ar, 64'(power_r_q) << 6, zmag - ar);
        end else begin
            r.rgn = cbse_pkg::REGION_CORE;
            e = gauss_exponent(zmag);
        end
        r.shape = scaled_power(e);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, '0);
            end else begin
                if (m_tdata !== pending[0].shape)
                    report_mismatch("shape_value", m_tdata, pending[0].shape);
                if (m_tuser !== pending[0].rgn)
                    report_mismatch("region", 32'(m_tuser), 32'(pending[0].rgn));
                void'(pending.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            m_tready <= 1'b0;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic drain_pipe();
        while (pending.size() != 0) @(posedge aclk);
        repeat (PIPE_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(cbse_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            cbse_pkg::CFG_ALPHA_LEFT:  alpha_l_q = val[15:0];
            cbse_pkg::CFG_ALPHA_RIGHT: alpha_r_q = val[15:0];
            cbse_pkg::CFG_POWER_LEFT:  power_l_q = val[15:0];
            cbse_pkg::CFG_POWER_RIGHT: power_r_q = val[15:0];
            cbse_pkg::CFG_WIDTH:       width_q = val[23:0];
            cbse_pkg::CFG_CENTRE:      centre_q = val[23:0];
            cbse_pkg::CFG_PEAK_SCALE:  scale_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_mass(logic [23:0] x, bit known, shape_out_t res);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending.push_back(known ? res : predict_shape(x));
    endtask

    function automatic void add_cfg(cbse_pkg::cfg_idx_t idx, logic [31:0] val);
        stim_row_t r;
        r = '{1'b1, idx, val, 1'b0, '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_mass(logic [23:0] x, bit known = 0, logic [31:0] s = '0,
                                     cbse_pkg::region_t g = cbse_pkg::REGION_CORE);
        stim_row_t r;
        r = '{1'b0, CFG_UNUSED, {8'd0, x}, known, '{s, g}};
        directed_rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_extreme(int w, bit sgn);
        case ($urandom_range(5))
            0:       return '0;
            1:       return sgn ? (32'd1 << (w - 1)) : 32'((64'd1 << w) - 1);
            2:       return sgn ? ((32'd1 << (w - 1)) - 1) : 32'd1;
            default: return $urandom & 32'((64'd1 << w) - 1);
        endcase
    endfunction

    initial begin
        logic [63:0] c;
        int          signed off;
        int          signed xs;
        logic [31:0] v;
        shape_out_t  none;

        none = '0;
        c = floor_sqrt(64'd1 << 59);
        for (int i = 15; i >= 0; i--) begin
            half_coef[i] = c;
            c = floor_sqrt(c << 30);
        end
        mismatches = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        alpha_l_q = cbse_pkg::ALPHA_RST;
        alpha_r_q = cbse_pkg::ALPHA_RST;
        power_l_q = cbse_pkg::POWER_RST;
        power_r_q = cbse_pkg::POWER_RST;
        width_q = cbse_pkg::WIDTH_RST;
        centre_q = cbse_pkg::CENTRE_RST;
        scale_q = cbse_pkg::SCALE_RST;

        add_mass(24'h800000, 1, 32'd256, cbse_pkg::REGION_CORE);
        add_mass(24'h000000);
        add_mass(24'hFFFFFF);
        add_mass(24'h800000 + 24'd83886);
        add_mass(24'h800000 - 24'd83886);
        add_mass(24'h800000 + 24'd83887);
        add_mass(24'h800000 - 24'd83887);
        add_cfg(cbse_pkg::CFG_ALPHA_LEFT, 32'h8000);
        add_cfg(cbse_pkg::CFG_POWER_LEFT, 32'h0);
        add_mass(24'h000000);
        add_mass(24'hFFFFFF);
        add_cfg(cbse_pkg::CFG_ALPHA_RIGHT, 32'h0);
        add_mass(24'h800001);
        add_mass(24'hFFFFFF);
        add_cfg(cbse_pkg::CFG_ALPHA_RIGHT, 32'h7FFF);
        add_cfg(cbse_pkg::CFG_POWER_RIGHT, 32'hFFFF);
        add_mass(24'hFFFFFF);
        add_cfg(cbse_pkg::CFG_PEAK_SCALE, 32'hFFFF_FFFF);
        add_mass(24'h800000, 1, 32'hFFFF_FFFF, cbse_pkg::REGION_CORE);
        add_cfg(cbse_pkg::CFG_CENTRE, 32'h0);
        add_cfg(cbse_pkg::CFG_WIDTH, 32'hFF_FFFF);
        add_mass(24'h000000, 1, 32'hFFFF_FFFF, cbse_pkg::REGION_CORE);
        add_mass(24'hFFFFFF);
        add_cfg(CFG_UNUSED, 32'h1234_5678);
        add_cfg(cbse_pkg::CFG_WIDTH, 32'h0);
        add_mass(24'h000000, 1, 32'h0, cbse_pkg::REGION_INVALID);
        add_mass(24'hFFFFFF, 1, 32'h0, cbse_pkg::REGION_INVALID);
        add_cfg(cbse_pkg::CFG_CENTRE, 32'hFF_FFFF);
        add_cfg(cbse_pkg::CFG_WIDTH, 32'h1);
        add_mass(24'h000000);
        add_mass(24'hFFFFFF, 1, 32'hFFFF_FFFF, cbse_pkg::REGION_CORE);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].wr) begin
                s_tvalid <= 1'b0;
                drain_pipe();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_mass(directed_rows[i].val[23:0], directed_rows[i].known,
                          directed_rows[i].res);
            end
        end

        for (int ph = 0; ph < 24; ph++) begin
            s_tvalid <= 1'b0;
            drain_pipe();
            write_reg(cbse_pkg::CFG_ALPHA_LEFT, ($urandom_range(1)) ? pick_extreme(16, 1)
                                      : 32'($urandom_range(0, 32767) - 16384));
            write_reg(cbse_pkg::CFG_ALPHA_RIGHT, ($urandom_range(1)) ? pick_extreme(16, 1)
                                       : 32'($urandom_range(0, 32767) - 16384));
            write_reg(cbse_pkg::CFG_POWER_LEFT, ($urandom_range(1)) ? pick_extreme(16, 0)
                                      : 32'($urandom_range(0, 20000)));
            write_reg(cbse_pkg::CFG_POWER_RIGHT, ($urandom_range(1)) ? pick_extreme(16, 0)
                                       : 32'($urandom_range(0, 20000)));
            case ($urandom_range(7))
                0:       v = pick_extreme(24, 0);
                1:       v = $urandom_range(1, 255);
                default: v = $urandom_range(1024, 1 << 20);
            endcase
            write_reg(cbse_pkg::CFG_WIDTH, v);
            write_reg(cbse_pkg::CFG_CENTRE, pick_extreme(24, 0));
            write_reg(cbse_pkg::CFG_PEAK_SCALE, pick_extreme(32, 0));
            if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);

            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 46; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 46; end
                default: begin tx_idle_pct = 30; rx_idle_pct = 30; end
            endcase
            if (ph % 8 == 4) begin
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end

            for (int n = 0; n < ((ph % 8 == 4) ? 160 : 36); n++) begin
                if ($urandom_range(1)) begin
                    xs = int'($urandom & 32'hFF_FFFF);
                end else begin
                    off = int'($urandom_range(0, 12 * int'(width_q[23:4]) + 16));
                    xs = $urandom_range(1) ? int'(centre_q) + off : int'(centre_q) - off;
                    if (xs < 0) xs = 0;
                    if (xs > 32'hFF_FFFF) xs = 32'hFF_FFFF;
                end
                send_mass(xs[23:0], 0, none);
            end
        end

        s_tvalid <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_pipe();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
